@@ rtl/csm_pkg.sv @@
// Shared types and constants for the CSR sparse matrix-vector block.
`default_nettype none

package csm_pkg;

  // Item field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ROW_W   = 16;

  // Stream bus widths
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 48;

  // Result queue geometry
  localparam int unsigned OQ_DEPTH = 8;
  localparam int unsigned OQ_PTR_W = 3;
  localparam int unsigned OQ_CNT_W = 4;

  // Operation codes; code 3 is ignored
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_ACCUM = 2'd1,
    OP_CLOSE = 2'd2
  } op_e;

  // Item entering the multiply-accumulate stages
  typedef struct packed {
    logic             valid;
    op_e              op;
    logic [VAL_W-1:0] value;
  } mac_in_t;

  // One closed row
  typedef struct packed {
    logic [ROW_W-1:0] row_number;
    logic [VAL_W-1:0] row_result;
  } row_out_t;

endpackage

`default_nettype wire

@@ rtl/csm_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module csm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on enable, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/csm_mac.sv @@
// Multiply stage, row accumulator and row counter.
`default_nettype none

module csm_mac (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire csm_pkg::mac_in_t               mac_in_i,
  input  wire logic [csm_pkg::VAL_W-1:0]      vec_rdata_i,
  output logic                                push_o,
  output csm_pkg::row_out_t                   row_o
);

  logic                       p2_valid_q;
  csm_pkg::op_e               p2_op_q;
  logic [csm_pkg::VAL_W-1:0]  prod_q;
  logic [csm_pkg::VAL_W-1:0]  prod_d;
  logic [csm_pkg::VAL_W-1:0]  acc_q;
  logic [csm_pkg::ROW_W-1:0]  row_q;

  // Low word of the product; identical for signed and unsigned operands
  assign prod_d = mac_in_i.value * vec_rdata_i;

  // Register the product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else begin
      p2_valid_q <= mac_in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_op_q <= mac_in_i.op;
    prod_q  <= prod_d;
  end

  // Accumulate, or emit and clear on a row close
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      row_q <= '0;
    end else if (p2_valid_q) begin
      case (p2_op_q)
        csm_pkg::OP_ACCUM: begin
          acc_q <= acc_q + prod_q;
        end
        csm_pkg::OP_CLOSE: begin
          acc_q <= '0;
          row_q <= row_q + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign push_o           = p2_valid_q && (p2_op_q == csm_pkg::OP_CLOSE);
  assign row_o.row_result = acc_q;
  assign row_o.row_number = row_q;

endmodule

`default_nettype wire

@@ rtl/csm_outq.sv @@
// Result queue between the accumulator and the output stream.
`default_nettype none

module csm_outq (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire csm_pkg::row_out_t              push_data_i,
  output logic [csm_pkg::OQ_CNT_W-1:0]        count_o,
  output logic                                valid_o,
  input  wire logic                           ready_i,
  output csm_pkg::row_out_t                   data_o
);

  csm_pkg::row_out_t               ent_q [csm_pkg::OQ_DEPTH];
  logic [csm_pkg::OQ_PTR_W-1:0]    head_q, tail_q;
  logic [csm_pkg::OQ_CNT_W-1:0]    count_q;
  logic                            pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = ent_q[head_q];
  assign count_o = count_q;

  // Store pushed rows
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[tail_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        tail_q <= tail_q + 1'b1;
      end
      if (pop) begin
        head_q <= head_q + 1'b1;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/csr_sparse_matvec_top.sv @@
// Top level: CSR sparse matrix times dense vector, streamed.
//
// Items arrive on the s_axis channel. tuser carries the operation: load a
// vector element, accumulate a nonzero (matrix value times the stored vector
// element at its column) or close the current row. tdata carries the column
// and the value. Every close item yields one item on m_axis: the row's dot
// product and its row number (wrapping after 65535); other items yield none.
// Columns at or above VECTOR_DEPTH wrap modulo VECTOR_DEPTH.
//
// Throughput is one item per clock while s_axis_tready_o is high. A close
// accepted on s_axis passes the address stage, vector store read, multiply
// register and accumulate; it then pushes the row into the result queue,
// which drives m_axis. For depths below 1024 the first stage also forms the
// column quotient used for the wrap.
//
// Reset clears the pipeline, accumulator, row counter and result queue; the
// vector store keeps its contents and must be loaded before use. When the
// receiver stalls, up to eight results wait in the queue; s_axis_tready_o
// drops once queued results plus closes in flight reach eight.
`default_nettype none

module csr_sparse_matvec_top #(
  parameter int unsigned VECTOR_DEPTH = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // [9:0] column, [41:10] value, [47:42] zero
  input  wire logic [csm_pkg::S_TDATA_W-1:0]      s_axis_tdata_i,
  // [1:0] operation
  input  wire logic [csm_pkg::S_TUSER_W-1:0]      s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // [31:0] row_result, [47:32] row_number
  output logic      [csm_pkg::M_TDATA_W-1:0]      m_axis_tdata_o
);

  localparam int unsigned IdxW = $clog2(VECTOR_DEPTH);
  localparam int unsigned ColW = csm_pkg::COL_W;
  localparam int unsigned ValW = csm_pkg::VAL_W;
  localparam int unsigned CntW = csm_pkg::OQ_CNT_W;

  logic                      accept;
  csm_pkg::op_e              in_op;
  logic [ColW-1:0]           in_col;
  logic [ValW-1:0]           in_val;

  logic                      p0_valid_q;
  csm_pkg::op_e              p0_op_q;
  logic [ColW-1:0]           p0_col_q;
  logic [ValW-1:0]           p0_val_q;

  logic [IdxW-1:0]           idx;
  logic                      vec_we;
  logic [ValW-1:0]           vec_rdata;

  csm_pkg::mac_in_t          p1_q;
  logic                      push;
  csm_pkg::row_out_t         push_row;
  csm_pkg::row_out_t         out_row;
  logic [CntW-1:0]           oq_count;
  logic [CntW-1:0]           pending;
  logic                      p0_close, p1_close;

  // Unpack the input item
  assign in_op  = csm_pkg::op_e'(s_axis_tuser_i[csm_pkg::OP_W-1:0]);
  assign in_col = s_axis_tdata_i[ColW-1:0];
  assign in_val = s_axis_tdata_i[ColW +: ValW];
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // Hold back input while the queue could not take every close in flight
  assign p0_close = p0_valid_q && (p0_op_q == csm_pkg::OP_CLOSE);
  assign p1_close = p1_q.valid && (p1_q.op == csm_pkg::OP_CLOSE);
  assign pending  = oq_count + CntW'(p0_close) + CntW'(p1_close) + CntW'(push);
  assign s_axis_tready_o = (pending < CntW'(csm_pkg::OQ_DEPTH));

  // Address stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_valid_q <= 1'b0;
    end else begin
      p0_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p0_op_q  <= in_op;
      p0_col_q <= in_col;
      p0_val_q <= in_val;
    end
  end

  // Wrap the column into the store depth
  generate
    if (VECTOR_DEPTH < 1024) begin : g_wrap
      localparam int unsigned RecipShift = 20;
      localparam logic [20:0] Recip =
        21'((2**RecipShift + VECTOR_DEPTH - 1) / VECTOR_DEPTH);
      localparam logic [ColW-1:0] DepthCol = ColW'(VECTOR_DEPTH);

      logic [30:0]     quot_prod;
      logic [ColW-1:0] quot_q;
      logic [ColW-1:0] quot_back;
      logic [ColW-1:0] rem;

      // Quotient by reciprocal; exact for every 10-bit column
      assign quot_prod = 31'(in_col) * 31'(Recip);

      always_ff @(posedge clk_i) begin
        if (accept) begin
          quot_q <= quot_prod[RecipShift +: ColW];
        end
      end

      assign quot_back = quot_q * DepthCol;
      assign rem       = p0_col_q - quot_back;
      assign idx       = rem[IdxW-1:0];
    end else begin : g_direct
      assign idx = IdxW'(p0_col_q);
    end
  endgenerate

  // Vector store: loads write, accumulates read
  assign vec_we = p0_valid_q && (p0_op_q == csm_pkg::OP_LOAD);

  csm_ram #(
    .WIDTH (ValW),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .addr_i  (idx),
    .wdata_i (p0_val_q),
    .rdata_o (vec_rdata)
  );

  // Read stage, aligned with the store's read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
    end else begin
      p1_q.valid <= p0_valid_q;
      p1_q.op    <= p0_op_q;
      p1_q.value <= p0_val_q;
    end
  end

  csm_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mac_in_i    (p1_q),
    .vec_rdata_i (vec_rdata),
    .push_o      (push),
    .row_o       (push_row)
  );

  csm_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_row),
    .count_o     (oq_count),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .data_o      (out_row)
  );

  assign m_axis_tdata_o = {out_row.row_number, out_row.row_result};

  // Queue never overflows
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (oq_count < CntW'(csm_pkg::OQ_DEPTH)) || m_axis_tready_i)
    else $error("result pushed into a full queue");

  // Queue count stays in range
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_count <= CntW'(csm_pkg::OQ_DEPTH))
    else $error("result queue count out of range");

  // A close reaches the accumulator after the address, read and multiply registers
  a_close_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_op == csm_pkg::OP_CLOSE)) |-> ##3 push)
    else $error("close item lost in pipeline");

  // A result is pushed only for an accepted close
  a_push_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> $past(p1_close))
    else $error("result pushed without a close");

endmodule

`default_nettype wire
